FILE: rtl/core/i2cbs_pkg.sv
`default_nettype none

package i2cbs_pkg;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5,
    CMD_NACK  = 3'd6,
    CMD_CHECK = 3'd7
  } cmd_t;

  localparam int unsigned PHASE_W = 6;

  // Index of the last phase of each command sequence.
  localparam logic [PHASE_W-1:0] LAST_WRITE = PHASE_W'(23);
  localparam logic [PHASE_W-1:0] LAST_READ  = PHASE_W'(31);
  localparam logic [PHASE_W-1:0] LAST_CHECK = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] LAST_OTHER = PHASE_W'(3);

  // Sub-phase of one written bit: drive SDA, raise SCL, lower SCL.
  localparam logic [1:0] WSUB_DRIVE = 2'd0;
  localparam logic [1:0] WSUB_HIGH  = 2'd1;
  localparam logic [1:0] WSUB_LOW   = 2'd2;

  // Sub-phase of one read bit.
  localparam logic [1:0] RSUB_RELEASE = 2'd0;
  localparam logic [1:0] RSUB_HIGH    = 2'd1;
  localparam logic [1:0] RSUB_SAMPLE  = 2'd2;

  typedef struct packed {
    cmd_t               active;
    logic [PHASE_W-1:0] phase;
    logic [1:0]         wsub;
    logic [7:0]         shift;
    logic               scl;
    logic               sda;
    logic [7:0]         rx;
    logic               ack;
  } state_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;
    logic       rejected;
  } result_t;

  function automatic logic [PHASE_W-1:0] last_phase(input cmd_t c);
    logic [PHASE_W-1:0] r;
    unique case (c)
      CMD_WRITE: r = LAST_WRITE;
      CMD_READ:  r = LAST_READ;
      CMD_CHECK: r = LAST_CHECK;
      default:   r = LAST_OTHER;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/i2cbs_phase_logic.sv
`default_nettype none

// One bus tick: takes the current sequencer state and one registered word,
// and gives the next state and the result word for that tick.
module i2cbs_phase_logic (
  input  i2cbs_pkg::state_t  st,
  input  i2cbs_pkg::cmd_t    command,
  input  logic [7:0]         data_byte,
  input  logic               sda_in,
  output i2cbs_pkg::state_t  st_next,
  output i2cbs_pkg::result_t res
);

  logic                         accept_new;
  logic                         busy;
  logic                         done;
  logic                         rej;
  logic [i2cbs_pkg::PHASE_W-1:0] p;

  always_comb begin
    st_next    = st;
    busy       = 1'b0;
    done       = 1'b0;
    accept_new = (st.active == i2cbs_pkg::CMD_IDLE) && (command != i2cbs_pkg::CMD_IDLE);
    rej        = (st.active != i2cbs_pkg::CMD_IDLE) && (command != i2cbs_pkg::CMD_IDLE);

    if (accept_new) begin
      st_next.active = command;
      st_next.phase  = '0;
      st_next.wsub   = i2cbs_pkg::WSUB_DRIVE;
      st_next.shift  = (command == i2cbs_pkg::CMD_WRITE) ? data_byte : 8'h00;
    end

    p = st_next.phase;

    if (st_next.active != i2cbs_pkg::CMD_IDLE) begin
      busy = 1'b1;
      unique case (st_next.active)
        i2cbs_pkg::CMD_START: begin
          unique case (p[1:0])
            2'd0:    st_next.sda = 1'b1;
            2'd1:    st_next.scl = 1'b1;
            2'd2:    st_next.sda = 1'b0;
            default: st_next.scl = 1'b0;
          endcase
        end
        i2cbs_pkg::CMD_STOP: begin
          unique case (p[1:0])
            2'd0:    st_next.sda = 1'b0;
            2'd1:    st_next.scl = 1'b1;
            2'd2:    st_next.sda = 1'b1;
            default: st_next.scl = 1'b0;
          endcase
        end
        i2cbs_pkg::CMD_ACK, i2cbs_pkg::CMD_NACK: begin
          unique case (p[1:0])
            2'd0:    st_next.scl = 1'b0;
            2'd1:    st_next.sda = (st_next.active == i2cbs_pkg::CMD_NACK);
            2'd2:    st_next.scl = 1'b1;
            default: st_next.scl = 1'b0;
          endcase
        end
        i2cbs_pkg::CMD_CHECK: begin
          unique case (p[1:0])
            2'd0: st_next.sda = 1'b1;
            2'd1: st_next.scl = 1'b1;
            default: begin
              st_next.ack = sda_in;
              st_next.scl = 1'b0;
            end
          endcase
        end
        i2cbs_pkg::CMD_WRITE: begin
          unique case (st_next.wsub)
            i2cbs_pkg::WSUB_DRIVE: st_next.sda = st_next.shift[7];
            i2cbs_pkg::WSUB_HIGH:  st_next.scl = 1'b1;
            default: begin
              st_next.scl   = 1'b0;
              st_next.shift = {st_next.shift[6:0], 1'b0};
            end
          endcase
          st_next.wsub = (st_next.wsub == i2cbs_pkg::WSUB_LOW) ? i2cbs_pkg::WSUB_DRIVE
                                                              : st_next.wsub + 2'd1;
        end
        i2cbs_pkg::CMD_READ: begin
          unique case (p[1:0])
            i2cbs_pkg::RSUB_RELEASE: st_next.sda = 1'b1;
            i2cbs_pkg::RSUB_HIGH:    st_next.scl = 1'b1;
            i2cbs_pkg::RSUB_SAMPLE:  st_next.shift = {st_next.shift[6:0], sda_in};
            default:                 st_next.scl = 1'b0;
          endcase
        end
        default: begin
        end
      endcase

      if (p == i2cbs_pkg::last_phase(st_next.active)) begin
        done = 1'b1;
        if (st_next.active == i2cbs_pkg::CMD_READ) begin
          st_next.rx = st_next.shift;
        end
        st_next.active = i2cbs_pkg::CMD_IDLE;
        st_next.phase  = '0;
      end else begin
        st_next.phase = p + 1'b1;
      end
    end

    res.scl      = st_next.scl;
    res.sda_out  = st_next.sda;
    res.busy_res = busy;
    res.done_res = done;
    res.rx_byte  = st_next.rx;
    res.ack_bit  = st_next.ack;
    res.rejected = rej;
  end

endmodule

`default_nettype wire

FILE: rtl/core/i2c_master_bit_sequencer_top.sv
`default_nettype none

// Bit-level I2C master sequencer. Every input word is one bus delay tick and
// produces exactly one result word giving the SCL and SDA levels to drive for
// that tick, plus busy, done, the last received byte, the last sampled ack and
// a rejected flag. A nonzero command given while idle starts a sequence whose
// first phase is that same tick: start, stop, ack and nack take 4 ticks, check
// ack 3, a byte write 24 (3 per bit, MSB first) and a byte read 32 (4 per bit).
// Commands that arrive while a sequence runs are ignored and flagged. The block
// takes one word per clock cycle unless it stalls its input; a word goes through
// an input register, the phase logic, and a result register before its result
// appears on the outputs. The result register decouples the two channels: a
// stall on the result side only backs up the input once both registers hold
// words.
module i2c_master_bit_sequencer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] command,
  input  logic [7:0] data_byte,
  input  logic       sda_in,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       scl,
  output logic       sda_out,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] rx_byte,
  output logic       ack_bit,
  output logic       rejected
);

  // Input register stage.
  logic             in_full;
  i2cbs_pkg::cmd_t  in_command;
  logic [7:0]       in_data;
  logic             in_sda;

  // Result register stage.
  logic               out_full;
  i2cbs_pkg::result_t out_res;

  // Sequencer state, advanced once per word that leaves the input register.
  i2cbs_pkg::state_t  st;
  i2cbs_pkg::state_t  st_next;
  i2cbs_pkg::result_t res_next;

  logic out_free;
  logic in_move;
  logic in_take;

  assign out_free  = !out_full || !res_stall;
  assign in_move   = in_full && out_free;
  assign cmd_stall = in_full && !out_free;
  assign in_take   = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (in_move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_command <= i2cbs_pkg::cmd_t'(command);
      in_data    <= data_byte;
      in_sda     <= sda_in;
    end
  end

  // The phase logic sees the state as it stands before this tick.
  i2cbs_phase_logic u_phase (
    .st        (st),
    .command   (in_command),
    .data_byte (in_data),
    .sda_in    (in_sda),
    .st_next   (st_next),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.active <= i2cbs_pkg::CMD_IDLE;
      st.phase  <= '0;
      st.wsub   <= i2cbs_pkg::WSUB_DRIVE;
      st.shift  <= 8'h00;
      st.scl    <= 1'b1;
      st.sda    <= 1'b1;
      st.rx     <= 8'h00;
      st.ack    <= 1'b1;
    end else if (in_move) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (in_move) begin
      out_full <= 1'b1;
    end else if (!res_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_move) begin
      out_res <= res_next;
    end
  end

  assign res_valid = out_full;
  assign scl       = out_res.scl;
  assign sda_out   = out_res.sda_out;
  assign busy_res  = out_res.busy_res;
  assign done_res  = out_res.done_res;
  assign rx_byte   = out_res.rx_byte;
  assign ack_bit   = out_res.ack_bit;
  assign rejected  = out_res.rejected;

  // An idle sequencer always sits at phase zero.
  a_idle_phase_zero: assert property (@(posedge clk) disable iff (rst)
    (st.active == i2cbs_pkg::CMD_IDLE) |-> (st.phase == '0))
    else $error("idle sequencer with nonzero phase");

  // The phase never runs past the end of the active sequence.
  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    (st.active != i2cbs_pkg::CMD_IDLE) |-> (st.phase <= i2cbs_pkg::last_phase(st.active)))
    else $error("phase beyond end of sequence");

  // A rejection can only be reported on a busy tick, and done implies busy.
  a_flags_need_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (busy_res || (!rejected && !done_res)))
    else $error("rejected or done without busy");

  // A word leaving the input register always lands in the result register.
  a_move_fills_out: assert property (@(posedge clk) disable iff (rst)
    in_move |=> res_valid)
    else $error("word lost between stages");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cbs_pkg::*;

  // The limit only catches a block that has stopped moving words.
  localparam int CYCLE_LIMIT = 600000;
  // Length of the long receiver hold-off that backs the block up.
  localparam int HOLD_CYCLES = 120;
  // Only the first few mismatches are printed in full.
  localparam int MAX_REPORTS = 10;

  logic       clk = 1'b0;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  logic [2:0] command;
  logic [7:0] data_byte;
  logic       sda_in;
  logic       res_valid;
  logic       res_stall;
  logic       scl;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_bit;
  logic       rejected;

  // Our own copy of the sequencer state. It advances by one bus tick for
  // every word that the block accepts.
  cmd_t       seq_cmd;
  logic [5:0] seq_phase;
  logic [7:0] seq_shift;
  logic       line_scl;
  logic       line_sda;
  logic [7:0] last_rx;
  logic       last_ack;

  // Bus levels and flags still owed by the block, oldest first.
  result_t    bus_expect_q[$];

  int mismatches  = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  // quiet turns off idling on both sides for the closing stretch, no_gaps
  // turns it off for the sender only, and hold_req asks the receiver process
  // for one long hold-off.
  bit quiet   = 1'b0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_master_bit_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .data_byte (data_byte),
    .sda_in    (sda_in),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .scl       (scl),
    .sda_out   (sda_out),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .rx_byte   (rx_byte),
    .ack_bit   (ack_bit),
    .rejected  (rejected)
  );

  // Number of bus ticks that a command sequence occupies.
  function automatic int ticks_for(input cmd_t c);
    case (c)
      CMD_WRITE: return 24;
      CMD_READ:  return 32;
      CMD_CHECK: return 3;
      default:   return 4;
    endcase
  endfunction

  // Advances the bus model by one tick and returns what the block should
  // report for it. The accepting tick of a command is already its phase 0.
  function automatic result_t step_bus(input cmd_t c, input logic [7:0] d, input logic s);
    result_t r;
    int      p;
    r = '0;
    if (seq_cmd != CMD_IDLE) begin
      // Anything but a plain tick is turned away while a sequence runs,
      // on its final tick too.
      r.rejected = (c != CMD_IDLE);
    end else if (c != CMD_IDLE) begin
      seq_cmd   = c;
      seq_phase = '0;
      seq_shift = (c == CMD_WRITE) ? d : 8'h00;
    end
    if (seq_cmd != CMD_IDLE) begin
      p = seq_phase;
      r.busy_res = 1'b1;
      case (seq_cmd)
        CMD_START: begin
          case (p)
            0:       line_sda = 1'b1;
            1:       line_scl = 1'b1;
            2:       line_sda = 1'b0;
            default: line_scl = 1'b0;
          endcase
        end
        CMD_STOP: begin
          // Stop leaves SCL low after releasing SDA.
          case (p)
            0:       line_sda = 1'b0;
            1:       line_scl = 1'b1;
            2:       line_sda = 1'b1;
            default: line_scl = 1'b0;
          endcase
        end
        CMD_ACK, CMD_NACK: begin
          case (p)
            0:       line_scl = 1'b0;
            1:       line_sda = (seq_cmd == CMD_NACK);
            2:       line_scl = 1'b1;
            default: line_scl = 1'b0;
          endcase
        end
        CMD_CHECK: begin
          case (p)
            0:       line_sda = 1'b1;
            1:       line_scl = 1'b1;
            default: begin
              last_ack = s;
              line_scl = 1'b0;
            end
          endcase
        end
        CMD_WRITE: begin
          case (2'(p % 3))
            WSUB_DRIVE: line_sda = seq_shift[7];
            WSUB_HIGH:  line_scl = 1'b1;
            default: begin
              line_scl  = 1'b0;
              seq_shift = {seq_shift[6:0], 1'b0};
            end
          endcase
        end
        CMD_READ: begin
          case (2'(p % 4))
            RSUB_RELEASE: line_sda  = 1'b1;
            RSUB_HIGH:    line_scl  = 1'b1;
            RSUB_SAMPLE:  seq_shift = {seq_shift[6:0], s};
            default:      line_scl  = 1'b0;
          endcase
        end
        default: ;
      endcase
      if (p + 1 == ticks_for(seq_cmd)) begin
        r.done_res = 1'b1;
        if (seq_cmd == CMD_READ) last_rx = seq_shift;
        seq_cmd   = CMD_IDLE;
        seq_phase = '0;
      end else begin
        seq_phase = seq_phase + 1'b1;
      end
    end
    r.scl     = line_scl;
    r.sda_out = line_sda;
    r.rx_byte = last_rx;
    r.ack_bit = last_ack;
    return r;
  endfunction

  // Offers one word, possibly after a random gap, and waits for the block to
  // take it. Called at a rising edge; returns at the edge that accepted the
  // word with cmd_valid still high, so the next word follows without a hole.
  task automatic send_tick(input cmd_t c, input logic [7:0] d, input logic s);
    if (!quiet && !no_gaps && $urandom_range(0, 5) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    command   <= c;
    data_byte <= d;
    sda_in    <= s;
    do @(posedge clk); while (cmd_stall);
    bus_expect_q.push_back(step_bus(c, d, s));
    items_sent++;
  endtask

  // One well-formed command followed by the plain ticks that carry it to its
  // end. Now and then a tick carries a stray command, which must be rejected.
  // The SDA pattern is all low, all high, or random, so reads reach 8'h00 and
  // 8'hff as well as mixed bytes.
  task automatic run_sequence(input cmd_t c, input int reject_pct);
    int         sda_mode;
    logic [7:0] d;
    logic [7:0] filler;
    logic       s;
    cmd_t       tick_cmd;
    sda_mode = $urandom_range(0, 3);
    case ($urandom_range(0, 7))
      0:       d = 8'h00;
      1:       d = 8'hff;
      default: d = 8'($urandom);
    endcase
    for (int k = 0; k < ticks_for(c); k++) begin
      tick_cmd = (k == 0) ? c : CMD_IDLE;
      if (k != 0 && $urandom_range(0, 99) < reject_pct) tick_cmd = cmd_t'($urandom_range(1, 7));
      filler = (k == 0) ? d : 8'($urandom);
      s = (sda_mode == 0) ? 1'b0 : (sda_mode == 1) ? 1'b1 : 1'($urandom);
      send_tick(tick_cmd, filler, s);
    end
  endtask

  // Every short command at least once, plain idle ticks, a command offered in the
  // middle of a sequence and one offered on its last tick, and check ack
  // seeing both an acknowledge and a missing one.
  task automatic test_control_sequences();
    send_tick(CMD_IDLE, 8'h00, 1'b0);
    send_tick(CMD_IDLE, 8'hff, 1'b1);
    send_tick(CMD_START, 8'hff, 1'b0);
    send_tick(CMD_STOP, 8'h00, 1'b1);
    send_tick(CMD_IDLE, 8'h00, 1'b0);
    send_tick(CMD_CHECK, 8'h00, 1'b1);
    send_tick(CMD_CHECK, 8'h00, 1'b1);
    send_tick(CMD_IDLE, 8'h00, 1'b1);
    send_tick(CMD_IDLE, 8'h00, 1'b0);
    send_tick(CMD_CHECK, 8'h00, 1'b1);
    send_tick(CMD_IDLE, 8'h00, 1'b1);
    send_tick(CMD_IDLE, 8'h00, 1'b1);
    send_tick(CMD_ACK, 8'h00, 1'b0);
    send_tick(CMD_IDLE, 8'h00, 1'b0);
    send_tick(CMD_NACK, 8'h00, 1'b0);
    send_tick(CMD_IDLE, 8'h00, 1'b0);
    send_tick(CMD_NACK, 8'h00, 1'b1);
    for (int k = 0; k < 3; k++) send_tick(CMD_IDLE, 8'h00, 1'b1);
    send_tick(CMD_STOP, 8'h00, 1'b0);
    send_tick(CMD_WRITE, 8'hff, 1'b0);
    send_tick(CMD_READ, 8'hff, 1'b1);
    send_tick(CMD_IDLE, 8'h00, 1'b0);
  endtask

  // The bulk of the run: whole sequences with random content and a few idle
  // ticks between them, with idling on both sides.
  task automatic test_random_sequences();
    while (items_sent < 900) begin
      if ($urandom_range(0, 9) == 0) begin
        send_tick(CMD_IDLE, 8'($urandom), 1'($urandom));
      end else begin
        run_sequence(cmd_t'($urandom_range(1, 7)), ($urandom_range(0, 1) == 0) ? 0 : 20);
      end
    end
  endtask

  // Raw words with no regard for where the block is in a sequence.
  task automatic test_random_noise();
    repeat (150) begin
      if ($urandom_range(0, 1) == 0) begin
        send_tick(CMD_IDLE, 8'($urandom), 1'($urandom));
      end else begin
        send_tick(cmd_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // The receiver holds off for a long time while the sender keeps offering
  // words back to back, so both internal registers fill and the block has
  // to stall its input.
  task automatic test_backpressure();
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (4) run_sequence(cmd_t'($urandom_range(1, 7)), 10);
    no_gaps = 1'b0;
  endtask

  // Closing stretch at full rate with no idling anywhere.
  task automatic test_steady_stream();
    quiet = 1'b1;
    while (items_sent < 1300) run_sequence(cmd_t'($urandom_range(1, 7)), 10);
  endtask

  // Receiver side: random stall bursts, plus the one long hold-off that
  // test_backpressure asks for. A burst ends early once the quiet stretch
  // begins.
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
      end else if (!quiet && !rst && $urandom_range(0, 7) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) begin
          @(posedge clk);
          if (quiet) break;
        end
        res_stall <= 1'b0;
      end
    end
  end

  // Result checker. Each word that leaves the block is matched against the
  // oldest prediction; every field is covered by the compare and printed on
  // a mismatch.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      got = '{scl, sda_out, busy_res, done_res, rx_byte, ack_bit, rejected};
      if (bus_expect_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("tb: cycle %0d: result word with nothing expected", cycle_count);
        mismatches++;
      end else begin
        want = bus_expect_q.pop_front();
        if (got !== want) begin
          if (mismatches < MAX_REPORTS) begin
            $display("tb: cycle %0d: expected scl=%b sda=%b busy=%b done=%b rx=%h ack=%b rej=%b",
                     cycle_count, want.scl, want.sda_out, want.busy_res, want.done_res,
                     want.rx_byte, want.ack_bit, want.rejected);
            $display("tb: cycle %0d: actual   scl=%b sda=%b busy=%b done=%b rx=%h ack=%b rej=%b",
                     cycle_count, got.scl, got.sda_out, got.busy_res, got.done_res,
                     got.rx_byte, got.ack_bit, got.rejected);
          end
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a run that hangs ends here as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    command   <= CMD_IDLE;
    data_byte <= 8'h00;
    sda_in    <= 1'b1;

    // Both lines start released, the ack sample starts high, nothing runs.
    seq_cmd   = CMD_IDLE;
    seq_phase = '0;
    seq_shift = 8'h00;
    line_scl  = 1'b1;
    line_sda  = 1'b1;
    last_rx   = 8'h00;
    last_ack  = 1'b1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_control_sequences();
    test_random_sequences();
    test_random_noise();
    test_backpressure();
    test_steady_stream();

    // Stop offering words, collect everything still owed, then let the
    // two-stage pipeline run on to show any stray result word.
    cmd_valid <= 1'b0;
    while (bus_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
